// ===== rtl/mld_pkg.sv =====
// ----------------------------------------------------------------------------
// mld_pkg
// Shared types and constants for the magic/length deframer.
// ----------------------------------------------------------------------------
package mld_pkg;

	// header layout: 32-bit magic then 32-bit length, both big-endian
	localparam int unsigned HEADER_BYTES = 8;
	localparam int unsigned HDR_CNT_W    = $clog2(HEADER_BYTES);
	localparam int unsigned WORD_W       = 32;
	localparam int unsigned BYTE_W       = 8;

	// streaming payload widths
	localparam int unsigned S_TDATA_W = BYTE_W;          // in_byte
	localparam int unsigned M_TDATA_W = BYTE_W + WORD_W; // out_byte, frame_length
	localparam int unsigned STATUS_W  = 3;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_PAYLOAD       = 3'd0,
		ST_EMPTY         = 3'd1,
		ST_CLEAN_END     = 3'd2,
		ST_SHORT_HEADER  = 3'd3,
		ST_BAD_MAGIC     = 3'd4,
		ST_OVERSIZED     = 3'd5,
		ST_SHORT_PAYLOAD = 3'd6
	} status_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_FRAME_MAGIC     = 1'b0,
		REG_MAX_PAYLOAD_LEN = 1'b1
	} cfg_idx_t;

	localparam logic [WORD_W-1:0] MAX_LEN_RESET = 32'd65536;

	// one input item as held in the input register
	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              stream_end;
	} item_t;

	// one result item
	typedef struct packed {
		status_t           status;
		logic [BYTE_W-1:0] out_byte;
		logic              last_of_frame;
		logic [WORD_W-1:0] frame_length;
	} result_t;

	// handshake between the core and the output register
	typedef struct packed {
		logic    load;
		result_t res;
	} res_push_t;

endpackage

// ===== rtl/mld_in_stage.sv =====
// ----------------------------------------------------------------------------
// mld_in_stage
// Input register for the slave stream; holds one item until the core takes it.
// ----------------------------------------------------------------------------
module mld_in_stage import mld_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [7:0] in_byte
	input  logic                 s_tuser,  // [0] stream_end
	input  logic                 advance,  // core consumes the held item
	output logic                 valid_s1,
	output item_t                item_s1
);

	// free slot, or the held item leaves this cycle
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.in_byte    <= s_tdata[BYTE_W-1:0];
			item_s1.stream_end <= s_tuser;
		end
	end

endmodule

// ===== rtl/mld_core.sv =====
// ----------------------------------------------------------------------------
// mld_core
// Framing state, config registers and per-item decision logic.
// ----------------------------------------------------------------------------
module mld_core import mld_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  cfg_idx_t          cfg_index,
	input  logic [WORD_W-1:0] cfg_data,
	input  logic              step,      // held item is processed this cycle
	input  item_t             item_s1,
	output res_push_t         push
);

	logic [WORD_W-1:0]    frame_magic_q;
	logic [WORD_W-1:0]    max_len_q;
	logic [HEADER_BYTES*BYTE_W-BYTE_W-1:0] hdr_shift_q;
	logic [HDR_CNT_W-1:0] hdr_cnt_q;
	logic                 in_payload_q;
	logic [WORD_W-1:0]    bytes_left_q;
	logic [WORD_W-1:0]    cur_len_q;

	logic [HEADER_BYTES*BYTE_W-1:0] hdr_full;
	logic [WORD_W-1:0]    hdr_magic;
	logic [WORD_W-1:0]    hdr_len;
	logic                 hdr_done;
	logic                 pay_last;

	// next-state values
	logic [HEADER_BYTES*BYTE_W-BYTE_W-1:0] hdr_shift_d;
	logic [HDR_CNT_W-1:0] hdr_cnt_d;
	logic                 in_payload_d;
	logic [WORD_W-1:0]    bytes_left_d;
	logic [WORD_W-1:0]    cur_len_d;
	logic                 res_valid;
	result_t              res;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_magic_q <= '0;
			max_len_q     <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_MAGIC:     frame_magic_q <= cfg_data;
				REG_MAX_PAYLOAD_LEN: max_len_q     <= cfg_data;
				default:             ;
			endcase
		end
	end

	// header word with the incoming byte appended
	assign hdr_full  = {hdr_shift_q, item_s1.in_byte};
	assign hdr_magic = hdr_full[2*WORD_W-1:WORD_W];
	assign hdr_len   = hdr_full[WORD_W-1:0];
	assign hdr_done  = (hdr_cnt_q == HDR_CNT_W'(HEADER_BYTES - 1));
	assign pay_last  = (bytes_left_q <= WORD_W'(1));

	// decision for one item
	always_comb begin
		hdr_shift_d  = hdr_shift_q;
		hdr_cnt_d    = hdr_cnt_q;
		in_payload_d = in_payload_q;
		bytes_left_d = bytes_left_q;
		cur_len_d    = cur_len_q;
		res_valid    = 1'b0;
		res.status        = ST_PAYLOAD;
		res.out_byte      = '0;
		res.last_of_frame = 1'b0;
		res.frame_length  = '0;

		priority if (item_s1.stream_end) begin
			res_valid = 1'b1;
			priority if (in_payload_q) begin
				res.status       = ST_SHORT_PAYLOAD;
				res.frame_length = cur_len_q;
			end else if (hdr_cnt_q == '0) begin
				res.status = ST_CLEAN_END;
			end else begin
				res.status = ST_SHORT_HEADER;
			end
			hdr_shift_d  = '0;
			hdr_cnt_d    = '0;
			in_payload_d = 1'b0;
			bytes_left_d = '0;
		end else if (in_payload_q) begin
			res_valid         = 1'b1;
			res.status        = ST_PAYLOAD;
			res.out_byte      = item_s1.in_byte;
			res.last_of_frame = pay_last;
			res.frame_length  = cur_len_q;
			if (pay_last) begin
				in_payload_d = 1'b0;
				bytes_left_d = '0;
			end else begin
				bytes_left_d = bytes_left_q - WORD_W'(1);
			end
		end else if (!hdr_done) begin
			hdr_shift_d = hdr_full[HEADER_BYTES*BYTE_W-BYTE_W-1:0];
			hdr_cnt_d   = hdr_cnt_q + HDR_CNT_W'(1);
		end else begin
			// full header: magic first, then length bound, then empty frame
			hdr_shift_d = '0;
			hdr_cnt_d   = '0;
			cur_len_d   = hdr_len;
			priority if (hdr_magic != frame_magic_q) begin
				res_valid        = 1'b1;
				res.status       = ST_BAD_MAGIC;
				res.frame_length = hdr_len;
			end else if (hdr_len > max_len_q) begin
				res_valid        = 1'b1;
				res.status       = ST_OVERSIZED;
				res.frame_length = hdr_len;
			end else if (hdr_len == '0) begin
				res_valid         = 1'b1;
				res.status        = ST_EMPTY;
				res.last_of_frame = 1'b1;
			end else begin
				in_payload_d = 1'b1;
				bytes_left_d = hdr_len;
			end
		end
	end

	// framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_shift_q  <= '0;
			hdr_cnt_q    <= '0;
			in_payload_q <= 1'b0;
			bytes_left_q <= '0;
			cur_len_q    <= '0;
		end else if (step) begin
			hdr_shift_q  <= hdr_shift_d;
			hdr_cnt_q    <= hdr_cnt_d;
			in_payload_q <= in_payload_d;
			bytes_left_q <= bytes_left_d;
			cur_len_q    <= cur_len_d;
		end
	end

	assign push.load = step && res_valid;
	assign push.res  = res;

	// header count is idle while payload bytes flow
	a_pay_no_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> hdr_cnt_q == '0)
		else $error("header count nonzero in payload phase");

	// remaining count stays within the frame length
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (bytes_left_q != '0) && (bytes_left_q <= cur_len_q))
		else $error("bytes_left out of range");

	// final payload byte ends the payload phase
	a_last_exit: assert property (@(posedge clk) disable iff (!arst_n)
		step && in_payload_q && !item_s1.stream_end && pay_last |=> !in_payload_q)
		else $error("payload phase not left after last byte");

	// last flag only on payload bytes and empty frames
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		push.load && push.res.last_of_frame |->
			(push.res.status == ST_PAYLOAD) || (push.res.status == ST_EMPTY))
		else $error("last_of_frame on a non-frame status");

endmodule

// ===== rtl/mld_out_reg.sv =====
// ----------------------------------------------------------------------------
// mld_out_reg
// Result register for the master stream.
// ----------------------------------------------------------------------------
module mld_out_reg import mld_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  res_push_t            push,
	output logic                 room,     // register can take a result now
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // [7:0] out_byte, [39:8] frame_length
	output logic [STATUS_W-1:0]  m_tuser,  // [2:0] status
	output logic                 m_tlast   // last_of_frame
);

	result_t res_q;

	assign room = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (push.load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.load) begin
			res_q <= push.res;
		end
	end

	assign m_tdata = {res_q.frame_length, res_q.out_byte};
	assign m_tuser = res_q.status;
	assign m_tlast = res_q.last_of_frame;

endmodule

// ===== rtl/magic_length_deframer.sv =====
// ----------------------------------------------------------------------------
// magic_length_deframer
// Splits a byte stream into frames with a magic word and a length header.
//
// Input stream: one byte per transaction in s_tdata; s_tuser high marks end
// of stream (byte ignored). Each frame is an 8-byte header (big-endian magic,
// big-endian length) followed by length payload bytes.
// Output stream: m_tuser is the status, m_tdata carries the payload byte and
// the frame length, m_tlast flags the final payload byte or an empty frame.
// Header bytes and an accepted nonzero-length header produce no output;
// errors and end of stream produce a single status transaction.
// Config: cfg_we writes cfg_data to register cfg_index (0 magic, 1 max
// length); write only while the block is idle.
// Path: each input transaction passes the input register, then the result
// register. Throughput: one byte per cycle while the receiver takes results,
// set by the single decision stage between those two registers.
// Reset: framing returns to header hunt, magic 0, max length 65536, both
// streams empty. When the receiver stalls, the result register holds and
// the input side stops after one more byte is buffered.
// ----------------------------------------------------------------------------
module magic_length_deframer import mld_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [7:0] in_byte
	input  logic                 s_tuser,  // [0] stream_end
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // [7:0] out_byte, [39:8] frame_length
	output logic [STATUS_W-1:0]  m_tuser,  // [2:0] status
	output logic                 m_tlast,  // last_of_frame
	input  logic                 cfg_we,
	input  cfg_idx_t             cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	logic      valid_s1;
	item_t     item_s1;
	logic      room;
	logic      step;
	res_push_t push;

	// an item is processed when the result register can take its result
	assign step = valid_s1 && room;

	mld_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (room),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mld_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.item_s1   (item_s1),
		.push      (push)
	);

	mld_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for magic_length_deframer.
//
// Drives a byte stream with end-of-stream markers into the slave side in
// bursts with random gaps, while the master side stalls on changing patterns.
// Every accepted input transaction is fed to a framing predictor that keeps
// its own header and payload state. Every accepted result transaction is
// compared field by field with the oldest predicted result. The stream mixes
// well-formed frames, truncated frames, bad headers and noise, under several
// magic and maximum-length settings including the extremes.
// ----------------------------------------------------------------------------
module tb_top import mld_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// frame tracker and result checker
	class deframe_scoreboard;
		logic [WORD_W-1:0] magic_word;
		logic [WORD_W-1:0] max_len;
		logic [63:0]       hdr_shift;
		logic [3:0]        hdr_cnt;
		bit                payload_phase;
		logic [WORD_W-1:0] remaining;
		logic [WORD_W-1:0] cur_len;
		result_t           expected_q[$];
		int unsigned       mismatches;
		int unsigned       checked_results;
		int unsigned       status_seen[7];

		function new();
			magic_word = '0;
			max_len = MAX_LEN_RESET;
			cur_len = '0;
			mismatches = 0;
			checked_results = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			restart_hunt();
		endfunction

		function void restart_hunt();
			hdr_shift = '0;
			hdr_cnt = '0;
			payload_phase = 1'b0;
			remaining = '0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [WORD_W-1:0] val);
			case (idx)
				REG_FRAME_MAGIC:     magic_word = val;
				REG_MAX_PAYLOAD_LEN: max_len = val;
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// advance the framing state by one accepted input transaction
		function void note_input(logic [BYTE_W-1:0] b, logic at_end);
			result_t           r;
			bit                produce;
			logic [WORD_W-1:0] hdr_magic;
			logic [WORD_W-1:0] hdr_len;
			r = '0;
			produce = 1'b0;
			if (at_end) begin
				produce = 1'b1;
				if (payload_phase) begin
					r.status = ST_SHORT_PAYLOAD;
					r.frame_length = cur_len;
					restart_hunt();
				end else if (hdr_cnt == 0) begin
					r.status = ST_CLEAN_END;
				end else begin
					r.status = ST_SHORT_HEADER;
					restart_hunt();
				end
			end else if (payload_phase) begin
				produce = 1'b1;
				r.status = ST_PAYLOAD;
				r.out_byte = b;
				r.frame_length = cur_len;
				r.last_of_frame = (remaining <= 1);
				if (r.last_of_frame) restart_hunt();
				else remaining = remaining - 1;
			end else begin
				hdr_shift = {hdr_shift[55:0], b};
				hdr_cnt = hdr_cnt + 4'd1;
				if (hdr_cnt == HEADER_BYTES) begin
					hdr_magic = hdr_shift[63:32];
					hdr_len = hdr_shift[31:0];
					restart_hunt();
					cur_len = hdr_len;
					r.frame_length = hdr_len;
					produce = 1'b1;
					// magic is checked before the length
					if (hdr_magic != magic_word) begin
						r.status = ST_BAD_MAGIC;
					end else if (hdr_len > max_len) begin
						r.status = ST_OVERSIZED;
					end else if (hdr_len == 0) begin
						r.status = ST_EMPTY;
						r.last_of_frame = 1'b1;
					end else begin
						produce = 1'b0;
						payload_phase = 1'b1;
						remaining = hdr_len;
					end
				end
			end
			if (produce) expected_q.push_back(r);
		endfunction

		// compare one accepted result transaction with the oldest prediction
		function void check_result(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] ob,
				logic lst, logic [WORD_W-1:0] flen);
			result_t want;
			checked_results++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: status %0d byte %02h last %0b length %08h",
						st, ob, lst, flen);
				return;
			end
			want = expected_q.pop_front();
			if (want.status !== st || want.out_byte !== ob ||
					want.last_of_frame !== lst || want.frame_length !== flen) begin
				mismatches++;
				if (mismatches <= 10) begin
					$write("Mismatch on result %0d: expected status %0d byte %02h last %0b",
						checked_results, want.status, want.out_byte, want.last_of_frame);
					$display(" length %08h, got status %0d byte %02h last %0b length %08h",
						want.frame_length, st, ob, lst, flen);
				end
			end else begin
				status_seen[st]++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // [7:0] in_byte
	logic                 s_tuser;   // [0] stream_end
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;   // [7:0] out_byte, [39:8] frame_length
	logic [STATUS_W-1:0]  m_tuser;   // [2:0] status
	logic                 m_tlast;
	logic                 cfg_we;
	cfg_idx_t             cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	deframe_scoreboard sb;
	logic [WORD_W-1:0] cfg_magic;
	logic [WORD_W-1:0] cfg_max;
	int unsigned       burst_left;
	int unsigned       items_sent;
	int unsigned       settings_used;
	int unsigned       rx_left;
	int unsigned       rx_mode;
	logic [4:0]        rx_tick;

	magic_length_deframer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit: far above the slowest legal run
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// receiver: stall pattern is picked at random from four modes; result checking
	initial begin
		rx_left = 0;
		rx_mode = 0;
		rx_tick = '0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata[7:0], m_tlast, m_tdata[39:8]);
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		rx_tick <= rx_tick + 5'd1;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= (rx_tick[1:0] == 2'd0);
			default: m_tready <= (rx_tick < 5'd8);
		endcase
	end

	// one input transaction, inside a burst of random length
	task automatic send_item(input logic [BYTE_W-1:0] b, input logic at_end);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= at_end;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(b, at_end);
		items_sent++;
	endtask

	task automatic send_end();
		send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_bytes(input int unsigned n);
		repeat (n) send_item(BYTE_W'($urandom_range(0, 255)), 1'b0);
	endtask

	// big-endian magic then big-endian length
	task automatic send_header(input logic [WORD_W-1:0] magic, input logic [WORD_W-1:0] len);
		logic [63:0] hdr;
		hdr = {magic, len};
		for (int i = 7; i >= 0; i--) send_item(hdr[i*8 +: 8], 1'b0);
	endtask

	// sender stops until every predicted result has been taken
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		burst_left = 0;
	endtask

	// full drain plus room for a header byte still inside the pipeline
	task automatic settle_idle();
		hold_until_drained();
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(input logic [WORD_W-1:0] magic, input logic [WORD_W-1:0] maxlen);
		cfg_we <= 1'b1;
		cfg_index <= REG_FRAME_MAGIC;
		cfg_data <= magic;
		@(posedge clk);
		sb.write_reg(REG_FRAME_MAGIC, magic);
		cfg_index <= REG_MAX_PAYLOAD_LEN;
		cfg_data <= maxlen;
		@(posedge clk);
		sb.write_reg(REG_MAX_PAYLOAD_LEN, maxlen);
		cfg_we <= 1'b0;
		cfg_magic = magic;
		cfg_max = maxlen;
		settings_used++;
	endtask

	// mostly valid frames; some bad magic, oversized and truncated ones
	task automatic send_frame();
		logic [WORD_W-1:0] magic;
		logic [WORD_W-1:0] len;
		logic [WORD_W-1:0] room;
		int unsigned       k;
		int unsigned       n;
		magic = cfg_magic;
		if ($urandom_range(0, 11) == 0) magic = magic ^ (32'h1 << $urandom_range(0, 31));
		k = $urandom_range(0, 9);
		if (k == 0) begin
			len = '0;
		end else if (k <= 7) begin
			len = $urandom_range(1, 12);
			if (len > cfg_max) len = cfg_max;
		end else if (k == 8 && cfg_max != '1) begin
			room = ~cfg_max;
			len = cfg_max + 1 + ($urandom % room);
		end else begin
			len = (cfg_max == 0) ? '0 : $urandom_range(cfg_max, 1);
		end
		send_header(magic, len);
		if (magic == cfg_magic && len != 0 && len <= cfg_max) begin
			if (len <= 12 && $urandom_range(0, 7) != 0) begin
				send_bytes(len);
			end else begin
				n = $urandom_range(0, (len > 6) ? 6 : len - 1);
				send_bytes(n);
				send_end();
			end
		end
	endtask

	task automatic run_random(input int unsigned n);
		int unsigned stop_at;
		int unsigned pick;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				hold_until_drained();
			end else if (pick < 62) begin
				send_frame();
			end else if (pick < 72) begin
				send_end();
			end else if (pick < 82) begin
				// header cut short by end of stream
				send_bytes($urandom_range(1, 7));
				send_end();
			end else if (pick < 90) begin
				send_header($urandom, $urandom);
			end else begin
				send_bytes($urandom_range(1, 10));
				if ($urandom_range(0, 1) != 0) send_end();
			end
		end
	endtask

	// main sequence
	initial begin
		sb = new();
		burst_left = 0;
		items_sent = 0;
		settings_used = 0;
		cfg_magic = '0;
		cfg_max = MAX_LEN_RESET;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FRAME_MAGIC;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values: clean end, short header,
		// all-ones bad magic, payload then short payload
		send_item(8'hFF, 1'b1);
		send_item(8'h5A, 1'b0);
		send_item(8'h00, 1'b1);
		send_header(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_header(32'h0, 32'd2);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);
		settle_idle();

		// extremes: all-ones magic, zero max length; empty and oversized frames
		set_config(32'hFFFF_FFFF, 32'h0);
		send_header(32'hFFFF_FFFF, 32'h0);
		send_header(32'hFFFF_FFFF, 32'h1);
		run_random(230);
		settle_idle();

		set_config(32'h0, 32'hFFFF_FFFF);
		run_random(300);
		settle_idle();

		set_config($urandom, $urandom_range(1, 20));
		run_random(350);
		settle_idle();

		set_config($urandom, $urandom_range(1, 65535));
		run_random(330);

		// wait for the tail, then a little longer
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (20) @(posedge clk);

		$display("Covered %0d stream transactions and %0d results over %0d register settings",
			items_sent, sb.checked_results, settings_used);
		$write("Matched per status: payload %0d, empty %0d, clean end %0d, short header %0d,",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
		$display(" bad magic %0d, oversized %0d, short payload %0d; mismatches %0d",
			sb.status_seen[4], sb.status_seen[5], sb.status_seen[6], sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/mld_pkg.sv
rtl/mld_in_stage.sv
rtl/mld_core.sv
rtl/mld_out_reg.sv
rtl/magic_length_deframer.sv
tb/tb_top.sv
